// ===== rtl/nlt_pkg.sv =====
package nlt_pkg;
  localparam int unsigned TableEntries = 16;
  localparam int unsigned HistoryBits = 8;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam int unsigned HcW = $clog2(HistoryBits + 1);

  localparam logic [2:0] RegBaseMode = 3'd0;
  localparam logic [2:0] RegMyAddr = 3'd1;
  localparam logic [2:0] RegEmptyAddr = 3'd2;
  localparam logic [2:0] RegQualLimit = 3'd3;
  localparam logic [2:0] RegCostLimit = 3'd4;
  localparam logic [2:0] RegFreshStart = 3'd5;

  typedef struct packed {
    logic [15:0] addr;
    logic [15:0] cost;
    logic [7:0] out_q;
    logic [7:0] in_q;
    logic [HistoryBits-1:0] hist;
    logic [7:0] seq;
    logic [7:0] fresh;
  } entry_t;
endpackage

// ===== rtl/neighbor_link_table_top.sv =====
// Neighbor table with parent choice. One item (beacon or aging tick) is
// processed at a time; busy_o is high while it runs. A beacon runs at most
// a match scan, a replace scan, the entry update, a parent scan, the parent
// read and the result, a tick an aging scan, the parent update and the
// result; each scan reads the table memory one entry per cycle into a
// register. done_o pulses in the same cycle that busy_o falls, carries the
// result and cannot be stalled. Write registers only while busy_o is low.
// Reset leaves the table cleared by a pass over all TableEntries entries
// during which busy_o is high.
module neighbor_link_table_top
  import nlt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cmd_i,
  input  logic [15:0] source_addr_i,
  input  logic [15:0] neighbor_cost_i,
  input  logic [7:0]  beacon_seq_i,
  input  logic [7:0]  quality_for_me_i,
  output logic        done_o,
  output logic [3:0]  parent_index_o,
  output logic [15:0] next_hop_o,
  output logic [15:0] best_cost_o,
  output logic        pull_request_o,
  output logic        entry_taken_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MATCH, S_REPL, S_UPD_RD, S_UPD, S_PAR, S_PAR_HOP,
    S_TICK, S_TICK_END, S_DONE
  } state_e;

  state_e state_q;
  entry_t mem [TableEntries];
  entry_t rd_q;
  logic [IdxW-1:0] rd_addr;
  logic rd_en, wr_en;
  logic [IdxW-1:0] wr_addr;
  entry_t wr_data;

  logic [CntW-1:0] cnt_q;     // issue counter
  logic [IdxW-1:0] ridx_q;    // index of entry now in rd_q
  logic rvalid_q;

  logic base_q;
  logic [15:0] my_q, empty_q, climit_q;
  logic [7:0] qlim_q, fstart_q;
  logic [IdxW-1:0] parent_q;
  logic [15:0] best_q, hop_q;

  logic cmd_q;
  logic [15:0] src_q, ncost_q;
  logic [7:0] seq_q, qual_q;
  logic found_q, none_q;
  logic [IdxW-1:0] sel_q, pick_q;
  logic pick_v_q;
  logic [15:0] pick_addr_q;
  logic [16:0] worst_q, pbest_q;
  logic clr_q;

  assign pready = 1'b1;
  assign busy_o = (state_q != S_IDLE);

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      RegBaseMode:   prdata = {31'd0, base_q};
      RegMyAddr:     prdata = {16'd0, my_q};
      RegEmptyAddr:  prdata = {16'd0, empty_q};
      RegQualLimit:  prdata = {24'd0, qlim_q};
      RegCostLimit:  prdata = {16'd0, climit_q};
      RegFreshStart: prdata = {24'd0, fstart_q};
      default:       prdata = '0;
    endcase
  end

  // combinational helpers on rd_q
  logic [16:0] sum;
  logic usable;
  assign sum = {1'b0, rd_q.cost} + {9'd0, rd_q.out_q};
  assign usable = {1'b0, rd_q.cost} < (17'h0ffff - {9'd0, rd_q.out_q});

  // beacon update of the selected entry
  entry_t upd;
  logic [7:0] gap;
  logic [HcW-1:0] hc;
  logic signed [9:0] v;
  always_comb begin
    upd = rd_q;
    if (clr_q) begin
      upd.addr = src_q;
      upd.cost = 16'hffff;
      upd.out_q = 8'hff;
      upd.in_q = 8'hff;
      upd.hist = '0;
      upd.seq = '0;
    end
    upd.fresh = fstart_q;
    if (!base_q) begin
      upd.cost = ncost_q;
      if (qual_q != 8'd0) upd.out_q = qual_q;
    end
    gap = seq_q - upd.seq;
    if (gap == 8'd0 || {1'b0, gap} >= 9'(HistoryBits)) upd.hist = '0;
    else upd.hist = upd.hist << gap;
    upd.hist[0] = 1'b1;
    upd.seq = seq_q;
    hc = '0;
    for (int k = 0; k < HistoryBits; k++) hc = hc + HcW'(upd.hist[k]);
    v = $signed({2'b0, qlim_q}) + 10'sd1 - $signed(10'(hc));
    upd.in_q = (v < 0 || v > $signed({2'b0, qlim_q})) ? 8'hff : v[7:0];
  end

  entry_t tick_e;
  always_comb begin
    tick_e = rd_q;
    if (rd_q.fresh == 8'd0) begin
      tick_e.addr = empty_q;
      tick_e.cost = 16'hffff;
      tick_e.out_q = 8'hff;
      tick_e.in_q = 8'hff;
      tick_e.hist = '0;
      tick_e.seq = '0;
    end else begin
      tick_e.fresh = rd_q.fresh - 8'd1;
    end
  end

  logic last_issue;
  assign last_issue = (cnt_q == CntW'(TableEntries - 1));

  always_comb begin
    rd_en = 1'b0;
    rd_addr = cnt_q[IdxW-1:0];
    wr_en = 1'b0;
    wr_addr = ridx_q;
    wr_data = upd;
    unique case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = cnt_q[IdxW-1:0];
        wr_data = '{addr: 16'hffff, cost: 16'hffff, out_q: 8'hff, in_q: 8'hff,
                    hist: '0, seq: '0, fresh: '0};
      end
      S_MATCH, S_REPL, S_PAR, S_TICK: rd_en = (cnt_q < CntW'(TableEntries));
      S_UPD_RD: begin
        rd_en = 1'b1;
        rd_addr = sel_q;
      end
      S_UPD: begin
        wr_en = 1'b1;
        wr_addr = sel_q;
      end
      S_TICK_END: ;
      S_PAR_HOP: begin
        rd_en = 1'b1;
        rd_addr = pick_v_q ? pick_q : parent_q;
      end
      default: ;
    endcase
    if (state_q == S_TICK && rvalid_q && rd_q.addr != empty_q) begin
      wr_en = 1'b1;
      wr_addr = ridx_q;
      wr_data = tick_e;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q <= '0;
      ridx_q <= '0;
      rvalid_q <= 1'b0;
      base_q <= 1'b0;
      my_q <= '0;
      empty_q <= 16'hffff;
      qlim_q <= 8'd7;
      climit_q <= 16'd65000;
      fstart_q <= 8'd5;
      parent_q <= '0;
      best_q <= 16'hffff;
      hop_q <= 16'hffff;
      done_o <= 1'b0;
      parent_index_o <= '0;
      next_hop_o <= '0;
      best_cost_o <= '0;
      pull_request_o <= 1'b0;
      entry_taken_o <= 1'b0;
      cmd_q <= 1'b0;
      src_q <= '0;
      ncost_q <= '0;
      seq_q <= '0;
      qual_q <= '0;
      found_q <= 1'b0;
      none_q <= 1'b0;
      sel_q <= '0;
      pick_q <= '0;
      pick_v_q <= 1'b0;
      pick_addr_q <= '0;
      worst_q <= '0;
      pbest_q <= '0;
      clr_q <= 1'b0;
    end else begin
      done_o <= 1'b0;
      rvalid_q <= rd_en;
      ridx_q <= rd_addr;
      if (cfg_wr) begin
        unique case (paddr[4:2])
          RegBaseMode: begin
            base_q <= pwdata[0];
            parent_q <= '0;
            best_q <= pwdata[0] ? 16'd0 : 16'hffff;
            hop_q <= pwdata[0] ? my_q : empty_q;
          end
          RegMyAddr:     my_q <= pwdata[15:0];
          RegEmptyAddr:  empty_q <= pwdata[15:0];
          RegQualLimit:  qlim_q <= pwdata[7:0];
          RegCostLimit:  climit_q <= pwdata[15:0];
          RegFreshStart: fstart_q <= pwdata[7:0];
          default: ;
        endcase
      end
      if (rd_en && state_q != S_UPD_RD && state_q != S_PAR_HOP) cnt_q <= cnt_q + 1'b1;
      unique case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_issue) begin
            state_q <= S_IDLE;
            cnt_q <= '0;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            cmd_q <= cmd_i;
            src_q <= source_addr_i;
            ncost_q <= neighbor_cost_i;
            seq_q <= beacon_seq_i;
            qual_q <= quality_for_me_i;
            cnt_q <= '0;
            found_q <= 1'b0;
            clr_q <= 1'b0;
            none_q <= 1'b1;
            pick_v_q <= 1'b0;
            pbest_q <= 17'h0ffff;
            worst_q <= {1'b0, neighbor_cost_i};
            if (cmd_i) state_q <= S_TICK;
            else if (source_addr_i == empty_q) state_q <= S_PAR;
            else state_q <= S_MATCH;
          end
        end
        S_MATCH: begin
          if (rvalid_q && !found_q && rd_q.addr == src_q) begin
            found_q <= 1'b1;
            sel_q <= ridx_q;
          end
          if (rvalid_q && ridx_q == IdxW'(TableEntries - 1)) begin
            cnt_q <= '0;
            if (found_q || rd_q.addr == src_q) state_q <= S_UPD_RD;
            else state_q <= S_REPL;
          end
        end
        S_REPL: begin
          if (rvalid_q && !clr_q) begin
            if (rd_q.addr == empty_q) begin
              clr_q <= 1'b1;
              found_q <= 1'b1;
              sel_q <= ridx_q;
            end else if (!base_q && worst_q < {1'b0, rd_q.cost}) begin
              worst_q <= {1'b0, rd_q.cost};
              found_q <= 1'b1;
              sel_q <= ridx_q;
            end
          end
          if (rvalid_q && ridx_q == IdxW'(TableEntries - 1)) begin
            cnt_q <= '0;
            clr_q <= 1'b1;
            if (found_q || (!clr_q && (rd_q.addr == empty_q ||
                (!base_q && worst_q < {1'b0, rd_q.cost})))) state_q <= S_UPD_RD;
            else state_q <= S_PAR;
          end
        end
        S_UPD_RD: state_q <= S_UPD;
        S_UPD: begin
          cnt_q <= '0;
          state_q <= S_PAR;
        end
        S_PAR: begin
          if (base_q) begin
            state_q <= S_DONE;
          end else begin
            if (rvalid_q && usable && sum < pbest_q) begin
              pbest_q <= sum;
              pick_q <= ridx_q;
              pick_v_q <= 1'b1;
            end
            if (rvalid_q && ridx_q == IdxW'(TableEntries - 1)) state_q <= S_PAR_HOP;
          end
        end
        S_PAR_HOP: begin
          if (pick_v_q) parent_q <= pick_q;
          best_q <= pbest_q[15:0];
          state_q <= S_TICK_END;
        end
        S_TICK: begin
          if (rvalid_q && rd_q.addr != empty_q && rd_q.fresh != 8'd0) begin
            if (base_q) none_q <= 1'b0;
            else begin
              if (rd_q.out_q <= qlim_q) none_q <= 1'b0;
              if (usable && sum < pbest_q) begin
                pbest_q <= sum;
                pick_q <= ridx_q;
                pick_v_q <= 1'b1;
                pick_addr_q <= rd_q.addr;
              end
            end
          end
          if (rvalid_q && ridx_q == IdxW'(TableEntries - 1)) state_q <= S_TICK_END;
        end
        S_TICK_END: begin
          if (!cmd_q) begin
            // rd_q holds the parent entry after S_PAR_HOP
            hop_q <= (pbest_q > {1'b0, climit_q}) ? empty_q : rd_q.addr;
          end else if (!base_q) begin
            best_q <= pbest_q[15:0];
            if (!pick_v_q) begin
              parent_q <= '0;
              hop_q <= empty_q;
            end else if (pick_q != parent_q) begin
              parent_q <= pick_q;
              hop_q <= (pbest_q > {1'b0, climit_q}) ? empty_q : pick_addr_q;
            end
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          done_o <= 1'b1;
          parent_index_o <= 4'(parent_q);
          next_hop_o <= hop_q;
          best_cost_o <= best_q;
          pull_request_o <= cmd_q & none_q;
          entry_taken_o <= !cmd_q && found_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done not a pulse");
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("start not taken");
  a_no_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !wr_en) else $error("write while idle");
`endif

endmodule
